// File: rtl/assert_macros.svh
// Assertion macros shared by the segment-to-circle point mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled during reset.
`define STCPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define STCPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/stcpm_pkg.sv
// Shared constants, types and arithmetic helpers of the point mapper.
package stcpm_pkg;

    // Fixed point: fractional bits of all coordinates and weights
    localparam int FRAC_BITS   = 28;
    // Quotient bits of the unit-coordinate divide (value never exceeds one)
    localparam int QUO_BITS    = FRAC_BITS + 1;
    // One root bit per stage for a 64-bit radicand
    localparam int SQRT_STAGES = 32;

    localparam logic [28:0]        ONE_U  = 29'(64'd1 << FRAC_BITS);
    localparam logic [63:0]        HALF_U = 64'd1 << (FRAC_BITS - 1);
    localparam logic [30:0]        W_MAX  = 31'h7fff_ffff;
    localparam logic signed [31:0] UNIT_Q = 32'(64'd1 << FRAC_BITS);

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_PAIR_MODE    = 3'd0,
        REG_VERTEX_ZERO  = 3'd1,
        REG_VERTEX_ONE   = 3'd2,
        REG_VERTEX_TWO   = 3'd3,
        REG_VERTEX_THREE = 3'd4
    } reg_idx_t;

    // Segment pairing; the unused code acts as distant
    typedef enum logic [1:0] {
        MODE_IDENT   = 2'd0,
        MODE_COMMON  = 2'd1,
        MODE_DISTANT = 2'd2
    } mode_t;

    // Item data carried alongside the root stages
    typedef struct packed {
        logic signed [31:0] px1;
        logic signed [31:0] py1;
        logic signed [31:0] px2;
        logic signed [31:0] py2;
        logic [30:0]        w;
        logic               last;
    } side_t;

    // Item flags carried alongside the divide stages
    typedef struct packed {
        logic neg1x;
        logic neg1y;
        logic neg2x;
        logic neg2y;
        logic z1;
        logic z2;
        logic last;
    } tail_t;

    // Weight factors waiting for their multiply slot
    typedef struct packed {
        logic [31:0] l2;
        logic [31:0] r1;
        logic [31:0] r2;
    } fac_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Saturating difference b - a of two signed coordinates
    function automatic logic signed [31:0] diff32(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat32(64'(b) - 64'(a));
    endfunction

    // Weight product back to fixed point, round half up, saturate
    function automatic logic [30:0] wround(input logic [63:0] p);
        logic [63:0] r;
        r = (p + HALF_U) >> FRAC_BITS;
        return (r > 64'(W_MAX)) ? W_MAX : r[30:0];
    endfunction

endpackage

// File: rtl/stcpm_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module stcpm_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import stcpm_pkg::*;

    logic [63:0] n_reg   [SQRT_STAGES];
    logic [63:0] res_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_prev, res_prev, trial, n_next, res_next;

        if (k == 0) begin : g_first
            assign n_prev   = radicand;
            assign res_prev = '0;
        end else begin : g_rest
            assign n_prev   = n_reg[k-1];
            assign res_prev = res_reg[k-1];
        end

        // Digit-by-digit restoring step
        always_comb begin
            trial = res_prev + BIT;
            if (n_prev >= trial) begin
                n_next   = n_prev - trial;
                res_next = (res_prev >> 1) + BIT;
            end else begin
                n_next   = n_prev;
                res_next = res_prev >> 1;
            end
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                n_reg[k]   <= n_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][31:0];

endmodule

// File: rtl/stcpm_div.sv
// Pipelined rounded divide of a magnitude by a radius, one quotient bit per stage.
module stcpm_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [31:0]                   dividend_mag,
    input  logic [31:0]                   divisor,
    output logic [stcpm_pkg::QUO_BITS-1:0] quotient
);
    import stcpm_pkg::*;

    localparam int NUM_W = 33 + FRAC_BITS;

    logic [31:0]         rem_reg [QUO_BITS];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS];
    logic [31:0]         dvs_reg [QUO_BITS];

    // Scaled numerator with half the divisor added for rounding
    logic [NUM_W-1:0] num;
    assign num = NUM_W'({dividend_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(divisor >> 1);

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic [31:0]         rem_prev, dvs_prev, rem_next;
        logic [QUO_BITS-1:0] low_prev, quo_prev, low_next, quo_next;
        logic [32:0]         trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_prev = num[NUM_W-1:QUO_BITS];
            assign low_prev = num[QUO_BITS-1:0];
            assign quo_prev = '0;
            assign dvs_prev = divisor;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign dvs_prev = dvs_reg[k-1];
        end

        // Shift in next numerator bit, subtract when it fits
        always_comb begin
            trial    = {rem_prev, low_prev[QUO_BITS-1]};
            ge       = trial >= {1'b0, dvs_prev};
            rem_next = ge ? 32'(trial - {1'b0, dvs_prev}) : trial[31:0];
            low_next = low_prev << 1;
            quo_next = {quo_prev[QUO_BITS-2:0], ge};
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_next;
                quo_reg[k] <= quo_next;
                dvs_reg[k] <= dvs_prev;
            end
        end
    end

    assign quotient = quo_reg[QUO_BITS-1];

endmodule

// File: rtl/segment_to_circle_point_map.sv
// Top level of the segment-to-circle quadrature point mapper.
// Maps a reference pair (s, t, weight) onto two polygon segments chosen by
// pair_mode, projects both points onto the unit circle and scales the weight
// by both segment lengths and both radii, all in Q4.28. The pipeline takes
// one request per cycle and passes each one through five mapping and squaring
// stages, a 32-stage square root (one root bit per stage), a 29-stage divider
// (one quotient bit per stage) and an output register, with the weight
// multiplies running beside the divider. A stalled result freezes the whole
// pipeline; otherwise a request is taken every cycle.
// Vertices and mode are written through the 64-bit APB port at 8*index.
module segment_to_circle_point_map (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // point requests
    input  logic               point_valid,
    output logic               point_stall,
    input  logic [28:0]        s_ref,
    input  logic [28:0]        t_ref,
    input  logic [30:0]        weight_in,
    input  logic               last_point,
    // results
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] first_x,
    output logic signed [31:0] first_y,
    output logic signed [31:0] second_x,
    output logic signed [31:0] second_y,
    output logic [30:0]        weight_out,
    output logic               zero_radius,
    output logic               last_out
);
    import stcpm_pkg::*;

    localparam int VLD_LEN = 6 + SQRT_STAGES + QUO_BITS;
    localparam int WD_LEN  = QUO_BITS - 8;

    // ---------------- configuration registers ----------------
    mode_t       mode_reg;
    logic [63:0] vert0_reg, vert1_reg, vert2_reg, vert3_reg;
    reg_idx_t    cfg_idx;

    assign cfg_idx = reg_idx_t'(paddr[5:3]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDENT;
            vert0_reg <= '0;
            vert1_reg <= '0;
            vert2_reg <= '0;
            vert3_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_PAIR_MODE:    mode_reg  <= mode_t'(pwdata[1:0]);
                REG_VERTEX_ZERO:  vert0_reg <= pwdata;
                REG_VERTEX_ONE:   vert1_reg <= pwdata;
                REG_VERTEX_TWO:   vert2_reg <= pwdata;
                REG_VERTEX_THREE: vert3_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_PAIR_MODE:    prdata = {62'd0, mode_reg};
            REG_VERTEX_ZERO:  prdata = vert0_reg;
            REG_VERTEX_ONE:   prdata = vert1_reg;
            REG_VERTEX_TWO:   prdata = vert2_reg;
            REG_VERTEX_THREE: prdata = vert3_reg;
            default:          prdata = '0;
        endcase
    end

    // second segment endpoints
    logic [63:0] seg_a, seg_b;
    always_comb begin
        unique case (mode_reg)
            MODE_IDENT:
            begin
                seg_a = vert0_reg;
                seg_b = vert1_reg;
            end
            MODE_COMMON:
            begin
                seg_a = vert0_reg;
                seg_b = vert2_reg;
            end
            default:
            begin
                seg_a = vert2_reg;
                seg_b = vert3_reg;
            end
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic vld_reg [VLD_LEN];

    assign en           = !(result_valid && result_stall);
    assign point_stall  = !en;
    assign result_valid = vld_reg[VLD_LEN-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < VLD_LEN; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= point_valid;
            for (int i = 1; i < VLD_LEN; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- stage A: clamp, segment deltas ----------------
    logic [28:0]        s_a_reg, t_a_reg;
    logic [30:0]        w_a_reg;
    logic               last_a_reg;
    logic signed [31:0] d_a_reg [4];
    logic signed [31:0] b_a_reg [4];
    logic [28:0]        s_next, t_next;

    assign s_next = (s_ref > ONE_U) ? ONE_U : s_ref;
    assign t_next = (t_ref > ONE_U) ? ONE_U : t_ref;

    always_ff @(posedge clk) begin
        if (en)
        begin
            s_a_reg    <= s_next;
            t_a_reg    <= t_next;
            w_a_reg    <= weight_in;
            last_a_reg <= last_point;
            d_a_reg[0] <= diff32(vert0_reg[63:32], vert1_reg[63:32]);
            d_a_reg[1] <= diff32(vert0_reg[31:0], vert1_reg[31:0]);
            d_a_reg[2] <= diff32(seg_a[63:32], seg_b[63:32]);
            d_a_reg[3] <= diff32(seg_a[31:0], seg_b[31:0]);
            b_a_reg[0] <= vert0_reg[63:32];
            b_a_reg[1] <= vert0_reg[31:0];
            b_a_reg[2] <= seg_a[63:32];
            b_a_reg[3] <= seg_a[31:0];
        end
    end

    // ---------------- stage B: parameter products, length squares ----------------
    logic signed [63:0] prod_b_reg [4];
    logic [63:0]        sq_b_reg   [4];
    logic signed [31:0] b_b_reg    [4];
    logic [30:0]        w_b_reg;
    logic               last_b_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_b_reg[i] <= 64'(d_a_reg[i]) *
                                 $signed({35'd0, (i < 2) ? s_a_reg : t_a_reg});
                sq_b_reg[i]   <= 64'(mag32(d_a_reg[i])) * 64'(mag32(d_a_reg[i]));
                b_b_reg[i]    <= b_a_reg[i];
            end
            w_b_reg    <= w_a_reg;
            last_b_reg <= last_a_reg;
        end
    end

    // ---------------- stage C: mapped points, length sums ----------------
    logic signed [31:0] p_c_reg [4];
    logic [63:0]        lsum1_c_reg, lsum2_c_reg;
    logic [30:0]        w_c_reg;
    logic               last_c_reg;
    logic signed [31:0] p_next [4];

    // round half up, then add the base vertex with saturation
    always_comb begin
        for (int i = 0; i < 4; i++)
            p_next[i] = sat32(64'(b_b_reg[i]) +
                              ((prod_b_reg[i] + $signed(HALF_U)) >>> FRAC_BITS));
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                p_c_reg[i] <= p_next[i];
            lsum1_c_reg <= sq_b_reg[0] + sq_b_reg[1];
            lsum2_c_reg <= sq_b_reg[2] + sq_b_reg[3];
            w_c_reg     <= w_b_reg;
            last_c_reg  <= last_b_reg;
        end
    end

    // ---------------- stage D: point squares ----------------
    logic [63:0]        psq_d_reg [4];
    logic signed [31:0] p_d_reg   [4];
    logic [63:0]        lsum1_d_reg, lsum2_d_reg;
    logic [30:0]        w_d_reg;
    logic               last_d_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                psq_d_reg[i] <= 64'(mag32(p_c_reg[i])) * 64'(mag32(p_c_reg[i]));
                p_d_reg[i]   <= p_c_reg[i];
            end
            lsum1_d_reg <= lsum1_c_reg;
            lsum2_d_reg <= lsum2_c_reg;
            w_d_reg     <= w_c_reg;
            last_d_reg  <= last_c_reg;
        end
    end

    // ---------------- stage E: radius sums ----------------
    logic [63:0] lsum1_e_reg, lsum2_e_reg, rsum1_e_reg, rsum2_e_reg;
    side_t       side_e_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            lsum1_e_reg     <= lsum1_d_reg;
            lsum2_e_reg     <= lsum2_d_reg;
            rsum1_e_reg     <= psq_d_reg[0] + psq_d_reg[1];
            rsum2_e_reg     <= psq_d_reg[2] + psq_d_reg[3];
            side_e_reg.px1  <= p_d_reg[0];
            side_e_reg.py1  <= p_d_reg[1];
            side_e_reg.px2  <= p_d_reg[2];
            side_e_reg.py2  <= p_d_reg[3];
            side_e_reg.w    <= w_d_reg;
            side_e_reg.last <= last_d_reg;
        end
    end

    // ---------------- square roots ----------------
    logic [31:0] len1, len2, rad1, rad2;

    stcpm_sqrt u_sqrt_len1 (.clk(clk), .en(en), .radicand(lsum1_e_reg), .root(len1));
    stcpm_sqrt u_sqrt_len2 (.clk(clk), .en(en), .radicand(lsum2_e_reg), .root(len2));
    stcpm_sqrt u_sqrt_rad1 (.clk(clk), .en(en), .radicand(rsum1_e_reg), .root(rad1));
    stcpm_sqrt u_sqrt_rad2 (.clk(clk), .en(en), .radicand(rsum2_e_reg), .root(rad2));

    // item data delayed to match the roots
    side_t side_reg [SQRT_STAGES];

    always_ff @(posedge clk) begin
        if (en)
        begin
            side_reg[0] <= side_e_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    side_t side_q;
    assign side_q = side_reg[SQRT_STAGES-1];

    // ---------------- dividers ----------------
    logic [QUO_BITS-1:0] q1x, q1y, q2x, q2y;

    stcpm_div u_div_1x (.clk(clk), .en(en), .dividend_mag(mag32(side_q.px1)),
                        .divisor(rad1), .quotient(q1x));
    stcpm_div u_div_1y (.clk(clk), .en(en), .dividend_mag(mag32(side_q.py1)),
                        .divisor(rad1), .quotient(q1y));
    stcpm_div u_div_2x (.clk(clk), .en(en), .dividend_mag(mag32(side_q.px2)),
                        .divisor(rad2), .quotient(q2x));
    stcpm_div u_div_2y (.clk(clk), .en(en), .dividend_mag(mag32(side_q.py2)),
                        .divisor(rad2), .quotient(q2y));

    // flags alongside the divider
    tail_t tail_reg [QUO_BITS];
    tail_t tail_next;

    always_comb begin
        tail_next.neg1x = side_q.px1[31];
        tail_next.neg1y = side_q.py1[31];
        tail_next.neg2x = side_q.px2[31];
        tail_next.neg2y = side_q.py2[31];
        tail_next.z1    = (rad1 == 32'd0);
        tail_next.z2    = (rad2 == 32'd0);
        tail_next.last  = side_q.last;
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            tail_reg[0] <= tail_next;
            for (int i = 1; i < QUO_BITS; i++)
                tail_reg[i] <= tail_reg[i-1];
        end
    end

    // ---------------- weight chain: multiply, then round, four times ----------------
    fac_t        fac_reg [6];
    fac_t        fac_next;
    logic [63:0] wp0_reg, wp1_reg, wp2_reg, wp3_reg;
    logic [30:0] w1_reg, w2_reg, w3_reg, w4_reg;
    logic [30:0] wd_reg [WD_LEN];

    assign fac_next = '{l2: len2, r1: rad1, r2: rad2};

    always_ff @(posedge clk) begin
        if (en)
        begin
            fac_reg[0] <= fac_next;
            for (int i = 1; i < 6; i++)
                fac_reg[i] <= fac_reg[i-1];
            wp0_reg <= 64'(side_q.w) * 64'(len1);
            w1_reg  <= wround(wp0_reg);
            wp1_reg <= 64'(w1_reg) * 64'(fac_reg[1].l2);
            w2_reg  <= wround(wp1_reg);
            wp2_reg <= 64'(w2_reg) * 64'(fac_reg[3].r1);
            w3_reg  <= wround(wp2_reg);
            wp3_reg <= 64'(w3_reg) * 64'(fac_reg[5].r2);
            w4_reg  <= wround(wp3_reg);
            wd_reg[0] <= w4_reg;
            for (int i = 1; i < WD_LEN; i++)
                wd_reg[i] <= wd_reg[i-1];
        end
    end

    // ---------------- output stage ----------------
    logic signed [31:0] first_x_reg, first_y_reg, second_x_reg, second_y_reg;
    logic [30:0]        weight_out_reg;
    logic               zero_radius_reg, last_out_reg;
    tail_t              tail_q;

    assign tail_q = tail_reg[QUO_BITS-1];

    // restore sign; a point at the origin reads as zero
    function automatic logic signed [31:0] unit_val(input logic [QUO_BITS-1:0] q,
                                                    input logic neg, input logic z);
        logic [31:0] v;
        v = 32'(q);
        if (z)
            return '0;
        else
            return neg ? (~v + 32'd1) : v;
    endfunction

    always_ff @(posedge clk) begin
        if (en)
        begin
            first_x_reg     <= unit_val(q1x, tail_q.neg1x, tail_q.z1);
            first_y_reg     <= unit_val(q1y, tail_q.neg1y, tail_q.z1);
            second_x_reg    <= unit_val(q2x, tail_q.neg2x, tail_q.z2);
            second_y_reg    <= unit_val(q2y, tail_q.neg2y, tail_q.z2);
            weight_out_reg  <= wd_reg[WD_LEN-1];
            zero_radius_reg <= tail_q.z1 || tail_q.z2;
            last_out_reg    <= tail_q.last;
        end
    end

    assign first_x     = first_x_reg;
    assign first_y     = first_y_reg;
    assign second_x    = second_x_reg;
    assign second_y    = second_y_reg;
    assign weight_out  = weight_out_reg;
    assign zero_radius = zero_radius_reg;
    assign last_out    = last_out_reg;

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    `STCPM_ASSERT(a_zero_weight, result_valid && zero_radius |-> weight_out == 31'd0, "weight not zero at origin")
    `STCPM_ASSERT(a_unit_range, result_valid |-> first_x <= UNIT_Q && first_x >= -UNIT_Q, "first_x off circle")
    `STCPM_ASSERT_NEXT(a_advance, vld_reg[VLD_LEN-2] && !point_stall, result_valid, "request lost at output")

endmodule

// File: tb/tb.sv
// Self-checking testbench for the segment-to-circle point mapper.
`timescale 1ns / 100ps

module tb;
    import stcpm_pkg::*;

    // Expected mapped point, as the block should return it
    typedef struct {
        logic [31:0] fx, fy, sx, sy;
        logic [30:0] w;
        logic        zr, lst;
    } mapped_pt_t;

    // Expected-result store with its own copy of the registers
    class point_map_board;
        logic [1:0]  mode;
        logic [63:0] vtx [4];
        mapped_pt_t  pending [$];
        int          errors;

        function new();
            mode = 0;
            foreach (vtx[i]) vtx[i] = 0;
            errors = 0;
        endfunction

        function void write_reg(int idx, logic [63:0] val);
            if (idx == REG_PAIR_MODE) mode = val[1:0];
            else if (idx >= REG_VERTEX_ZERO && idx <= REG_VERTEX_THREE) vtx[idx - 1] = val;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint hi(logic [63:0] v);
            return longint'($signed(v[63:32]));
        endfunction

        function longint lo(logic [63:0] v);
            return longint'($signed(v[31:0]));
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint unsigned absv(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint unsigned radius(longint dx, longint dy);
            longint unsigned mx, my;
            mx = absv(dx);
            my = absv(dy);
            return root(mx * mx + my * my);
        endfunction

        function longint along(longint a, longint b, longint unsigned u);
            longint d;
            d = clip32(b - a);
            return clip32(a + ((d * longint'(u) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
        endfunction

        function logic [31:0] unit(longint v, longint unsigned r);
            longint unsigned q;
            q = ((absv(v) << FRAC_BITS) + (r >> 1)) / r;
            return v < 0 ? 32'(-q) : 32'(q);
        endfunction

        function longint unsigned scale(longint unsigned w, longint unsigned f);
            longint unsigned p;
            p = (w * f + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            return p > 64'h7fffffff ? 64'h7fffffff : p;
        endfunction

        // Map u along a->b onto the circle; returns the radius
        function longint unsigned project(logic [63:0] a, logic [63:0] b, longint unsigned u,
                                          output logic [31:0] ox, output logic [31:0] oy);
            longint px, py;
            longint unsigned r;
            px = along(hi(a), hi(b), u);
            py = along(lo(a), lo(b), u);
            r = radius(px, py);
            ox = r == 0 ? 32'd0 : unit(px, r);
            oy = r == 0 ? 32'd0 : unit(py, r);
            return r;
        endfunction

        function void note_request(logic [28:0] s, logic [28:0] t, logic [30:0] w, logic l);
            mapped_pt_t e;
            logic [63:0] a, b;
            longint unsigned su, tu, l1, l2, r1, r2, wv;
            su = s > ONE_U ? ONE_U : s;
            tu = t > ONE_U ? ONE_U : t;
            a = mode == MODE_IDENT ? vtx[0] : (mode == MODE_COMMON ? vtx[0] : vtx[2]);
            b = mode == MODE_IDENT ? vtx[1] : (mode == MODE_COMMON ? vtx[2] : vtx[3]);
            l1 = radius(clip32(hi(vtx[1]) - hi(vtx[0])), clip32(lo(vtx[1]) - lo(vtx[0])));
            l2 = radius(clip32(hi(b) - hi(a)), clip32(lo(b) - lo(a)));
            r1 = project(vtx[0], vtx[1], su, e.fx, e.fy);
            r2 = project(a, b, tu, e.sx, e.sy);
            wv = scale(scale(scale(scale(w, l1), l2), r1), r2);
            e.w = wv[30:0];
            e.zr = (r1 == 0 || r2 == 0);
            e.lst = l;
            pending.push_back(e);
        endfunction

        function void check_result(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx,
                                   logic [31:0] sy, logic [30:0] w, logic zr, logic lst);
            mapped_pt_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (fx !== e.fx) begin $error("first_x exp %h got %h", e.fx, fx); errors++; end
            if (fy !== e.fy) begin $error("first_y exp %h got %h", e.fy, fy); errors++; end
            if (sx !== e.sx) begin $error("second_x exp %h got %h", e.sx, sx); errors++; end
            if (sy !== e.sy) begin $error("second_y exp %h got %h", e.sy, sy); errors++; end
            if (w !== e.w) begin $error("weight_out exp %h got %h", e.w, w); errors++; end
            if (zr !== e.zr) begin $error("zero_radius exp %b got %b", e.zr, zr); errors++; end
            if (lst !== e.lst) begin $error("last_out exp %b got %b", e.lst, lst); errors++; end
        endfunction
    endclass

    localparam int LATENCY = 67;

    logic clk = 0, rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [5:0] paddr = 0;
    logic [63:0] pwdata = 0, prdata;
    logic pready;
    logic point_valid = 0, point_stall;
    logic [28:0] s_ref = 0, t_ref = 0;
    logic [30:0] weight_in = 0;
    logic last_point = 0;
    logic result_valid, result_stall = 0;
    logic signed [31:0] first_x, first_y, second_x, second_y;
    logic [30:0] weight_out;
    logic zero_radius, last_out;

    point_map_board board = new();

    segment_to_circle_point_map dut (.*);

    always #2 clk = ~clk;

    // Result side: stall pattern and checking
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(first_x, first_y, second_x, second_y, weight_out,
                               zero_radius, last_out);
        case (stall_mode)
            0: result_stall <= 0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ($urandom_range(0, 9) < 6);
        endcase
    end

    task automatic reg_write(int idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(8 * idx); pwdata <= val;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.write_reg(idx, val);
    endtask

    task automatic send_point(logic [28:0] s, logic [28:0] t, logic [30:0] w, logic l);
        point_valid <= 1; s_ref <= s; t_ref <= t; weight_in <= w; last_point <= l;
        do @(posedge clk); while (point_stall);
        board.note_request(s, t, w, l);
    endtask

    // Called right at the accepting edge of the last request
    task automatic drain();
        int n;
        point_valid <= 0;
        n = 0;
        while (board.pending.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 0;
            3: return $urandom;
            default: return 32'($signed(32'($urandom_range(0, 32'h20000000))) - 32'sh10000000);
        endcase
    endfunction

    function automatic logic [28:0] rand_param();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return ONE_U;
            2: return 29'($urandom);
            default: return 29'($urandom_range(0, ONE_U));
        endcase
    endfunction

    // Random points in bursts with gaps; ends on an accepted request
    task automatic random_points(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0)
            begin
                send_point(rand_param(), rand_param(),
                           $urandom_range(0, 3) == 0 ? 31'h7fffffff : 31'($urandom),
                           $urandom_range(0, 7) == 0);
                burst--;
                count--;
            end
            if (count > 0 && $urandom_range(0, 2) != 0)
            begin
                point_valid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // origin vertices: every point at origin
        send_point(0, 0, 31'h7fffffff, 1);
        drain();
        // unit square-ish geometry, each mode plus the unused code
        reg_write(REG_VERTEX_ZERO, {32'h10000000, 32'h0});
        reg_write(REG_VERTEX_ONE, {32'h0, 32'h10000000});
        reg_write(REG_VERTEX_TWO, {32'hf0000000, 32'h0});
        reg_write(REG_VERTEX_THREE, {32'h0, 32'hf0000000});
        for (int m = 0; m < 4; m++)
        begin
            reg_write(REG_PAIR_MODE, m);
            send_point(0, 0, 31'h10000000, 0);
            send_point(ONE_U, ONE_U, 31'h7fffffff, 0);
            send_point(29'h1fffffff, 29'h1fffffff, 31'h1, 1);
            send_point(ONE_U >> 1, ONE_U >> 1, 31'h10000000, 0);
            send_point(29'h0aaaaaaa, 29'h15555555, 31'h2aaaaaaa, 1);
            drain();
        end
        // extreme coordinates
        reg_write(REG_VERTEX_ZERO, {32'h80000000, 32'h7fffffff});
        reg_write(REG_VERTEX_ONE, {32'h7fffffff, 32'h80000000});
        reg_write(REG_PAIR_MODE, MODE_COMMON);
        send_point(0, ONE_U, 31'h7fffffff, 0);
        send_point(ONE_U >> 1, 0, 31'h55555555, 1);
        drain();
        // random phases with random settings
        for (int ph = 0; ph < 12; ph++)
        begin
            stall_mode = ph % 3;
            reg_write(REG_PAIR_MODE, $urandom_range(0, 3));
            for (int v = REG_VERTEX_ZERO; v <= REG_VERTEX_THREE; v++)
                reg_write(v, {rand_coord(), rand_coord()});
            random_points(100);
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
